[hw/rtl/wpbs_pkg.sv]
// ----------------------------------------------------------------------------
// wpbs_pkg
// Types and constants shared by the white pixel band steering block.
// ----------------------------------------------------------------------------
package wpbs_pkg;

  localparam int COUNT_W     = 21;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 11;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WHITE_LEVEL  = 2'd2;

  localparam logic [CFG_DATA_W-1:0] RST_FRAME_WIDTH  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] RST_FRAME_HEIGHT = 11'd480;
  localparam logic [7:0]            RST_WHITE_LEVEL  = 8'd255;

  localparam logic [1:0] DIR_STOP     = 2'd0;
  localparam logic [1:0] DIR_LEFT     = 2'd1;
  localparam logic [1:0] DIR_STRAIGHT = 2'd2;
  localparam logic [1:0] DIR_RIGHT    = 2'd3;

  typedef enum logic [1:0] {
    BAND_NONE   = 2'd0,
    BAND_LEFT   = 2'd1,
    BAND_CENTER = 2'd2,
    BAND_RIGHT  = 2'd3
  } band_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [1:0]         direction;
    logic [COUNT_W-1:0] left_count;
    logic [COUNT_W-1:0] center_count;
    logic [COUNT_W-1:0] right_count;
  } result_t;

  // classified pixel handed from front to back
  typedef struct packed {
    band_t band;
    logic  last;
  } token_t;

  typedef struct packed {
    logic   push;
    token_t data;
  } qwr_t;

  typedef struct packed {
    logic   full;
  } qwr_stat_t;

  typedef struct packed {
    logic   avail;
    token_t data;
  } qrd_t;

endpackage

[hw/rtl/wpbs_fifo.sv]
// ----------------------------------------------------------------------------
// wpbs_fifo
// Short token queue between the classifying front and the counting back.
// ----------------------------------------------------------------------------
module wpbs_fifo (
  input  logic               clk,
  input  logic               rst,
  input  wpbs_pkg::qwr_t     wr,
  output wpbs_pkg::qwr_stat_t wr_stat,
  output wpbs_pkg::qrd_t     rd,
  input  logic               pop
);
  import wpbs_pkg::*;

  token_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr;
  logic [QPTR_W-1:0]   rptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push;
  logic                do_pop;

  assign wr_stat.full = (count == QCNT_W'(QUEUE_DEPTH));
  assign rd.avail     = (count != '0);
  assign rd.data      = mem[rptr];
  assign do_push      = wr.push && !wr_stat.full;
  assign do_pop       = pop && rd.avail;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wptr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/wpbs_front.sv]
// ----------------------------------------------------------------------------
// wpbs_front
// Holds the frame geometry, tracks raster position and classifies each pixel
// into a column band.
// ----------------------------------------------------------------------------
module wpbs_front #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wpbs_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wpbs_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                pixel_valid,
  output logic                                pixel_ready,
  input  wpbs_pkg::pixel_t                    pixel,
  output wpbs_pkg::qwr_t                      qwr,
  input  wpbs_pkg::qwr_stat_t                 qwr_stat
);
  import wpbs_pkg::*;

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int HW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT + 1) : 1;
  localparam int MW = WW + 2;

  function automatic logic [WW-1:0] clamp_w(input logic [CFG_DATA_W-1:0] v);
    logic [WW-1:0] r;
    if (v == '0) begin
      r = WW'(1);
    end else if (32'(v) > MAX_WIDTH) begin
      r = WW'(MAX_WIDTH);
    end else begin
      r = WW'(v);
    end
    return r;
  endfunction

  function automatic logic [HW-1:0] clamp_h(input logic [CFG_DATA_W-1:0] v);
    logic [HW-1:0] r;
    if (v == '0) begin
      r = HW'(1);
    end else if (32'(v) > MAX_HEIGHT) begin
      r = HW'(MAX_HEIGHT);
    end else begin
      r = HW'(v);
    end
    return r;
  endfunction

  logic [WW-1:0] width_eff;
  logic [HW-1:0] height_eff;
  logic [7:0]    white_level;
  logic [CW-1:0] col;
  logic [RW-1:0] row;

  logic          accept;
  logic          is_white;
  logic          col_last;
  logic          row_last;
  logic [MW-1:0] c3;
  logic [MW-1:0] w1;
  logic [MW-1:0] w2;
  band_t         band;

  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff   <= clamp_w(RST_FRAME_WIDTH);
      height_eff  <= clamp_h(RST_FRAME_HEIGHT);
      white_level <= RST_WHITE_LEVEL;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_FRAME_WIDTH:  width_eff   <= clamp_w(cfg_data);
        CFG_FRAME_HEIGHT: height_eff  <= clamp_h(cfg_data);
        CFG_WHITE_LEVEL:  white_level <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign pixel_ready = !qwr_stat.full;
  assign accept      = pixel_valid && pixel_ready;

  assign is_white = (pixel.red == white_level) && (pixel.green == white_level) &&
                    (pixel.blue == white_level);
  assign c3       = MW'(col) + (MW'(col) << 1);
  assign w1       = MW'(width_eff);
  assign w2       = w1 << 1;
  assign col_last = (WW'(col) + WW'(1)) >= width_eff;
  assign row_last = (HW'(row) + HW'(1)) >= height_eff;

  always_comb begin
    band = BAND_NONE;
    if (is_white) begin
      if (c3 <= w1) begin
        band = BAND_LEFT;
      end else if (c3 < w2) begin
        band = BAND_CENTER;
      end else if (c3 > w2) begin
        band = BAND_RIGHT;
      end
    end
  end

  assign qwr.push      = accept;
  assign qwr.data.band = band;
  assign qwr.data.last = col_last && row_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      if (col_last) begin
        col <= '0;
        if (row_last) begin
          row <= '0;
        end else begin
          row <= row + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

[hw/rtl/wpbs_back.sv]
// ----------------------------------------------------------------------------
// wpbs_back
// Accumulates saturating band counts and emits the frame result with its
// steering command through an output register.
// ----------------------------------------------------------------------------
module wpbs_back (
  input  logic              clk,
  input  logic              rst,
  input  wpbs_pkg::qrd_t    qrd,
  output logic              pop,
  output logic              result_valid,
  input  logic              result_ready,
  output wpbs_pkg::result_t result
);
  import wpbs_pkg::*;

  logic [COUNT_W-1:0] left_total;
  logic [COUNT_W-1:0] center_total;
  logic [COUNT_W-1:0] right_total;
  logic [COUNT_W-1:0] left_next;
  logic [COUNT_W-1:0] center_next;
  logic [COUNT_W-1:0] right_next;
  logic [1:0]         dir_next;
  logic               slot_free;
  logic               take_last;

  function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  assign slot_free = !result_valid || result_ready;
  assign pop       = qrd.avail && (!qrd.data.last || slot_free);
  assign take_last = pop && qrd.data.last;

  always_comb begin
    left_next   = left_total;
    center_next = center_total;
    right_next  = right_total;
    case (qrd.data.band)
      BAND_LEFT:   left_next   = sat_inc(left_total);
      BAND_CENTER: center_next = sat_inc(center_total);
      BAND_RIGHT:  right_next  = sat_inc(right_total);
      default: ;
    endcase
  end

  always_comb begin
    if (left_next == '0 && center_next == '0 && right_next == '0) begin
      dir_next = DIR_STOP;
    end else if (left_next >= center_next && left_next >= right_next) begin
      dir_next = DIR_LEFT;
    end else if (center_next >= right_next) begin
      dir_next = DIR_STRAIGHT;
    end else begin
      dir_next = DIR_RIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_total   <= '0;
      center_total <= '0;
      right_total  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (take_last) begin
        left_total   <= '0;
        center_total <= '0;
        right_total  <= '0;
      end else if (pop) begin
        left_total   <= left_next;
        center_total <= center_next;
        right_total  <= right_next;
      end
      if (take_last) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_last) begin
      result.direction    <= dir_next;
      result.left_count   <= left_next;
      result.center_count <= center_next;
      result.right_count  <= right_next;
    end
  end

endmodule

[hw/rtl/white_pixel_band_steering.sv]
// ----------------------------------------------------------------------------
// white_pixel_band_steering
// Counts white pixels in three column bands per frame and emits a steering
// command with the counts after each frame's last pixel.
// ----------------------------------------------------------------------------
// Throughput: one pixel per cycle while the queue has room; the front
//   classifies, a 4-entry queue feeds the counting back end.
// Result path: the back end pops a frame's last pixel from the queue and sets
//   the registered result_valid, waiting while a prior result is still held.
// Reset: clears position, counts, queue and output valid; geometry returns to
//   640 x 480 and white level to 255.
module white_pixel_band_steering #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [wpbs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wpbs_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            pixel_valid,
  output logic                            pixel_ready,
  input  wpbs_pkg::pixel_t                pixel,
  output logic                            result_valid,
  input  logic                            result_ready,
  output wpbs_pkg::result_t               result
);
  import wpbs_pkg::*;

  qwr_t      qwr;
  qwr_stat_t qwr_stat;
  qrd_t      qrd;
  logic      pop;

  wpbs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .pixel_valid (pixel_valid),
    .pixel_ready (pixel_ready),
    .pixel       (pixel),
    .qwr         (qwr),
    .qwr_stat    (qwr_stat)
  );

  wpbs_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (qwr),
    .wr_stat (qwr_stat),
    .rd      (qrd),
    .pop     (pop)
  );

  wpbs_back u_back (
    .clk          (clk),
    .rst          (rst),
    .qrd          (qrd),
    .pop          (pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule

[hw/rtl/wpbs_checker.sv]
// ----------------------------------------------------------------------------
// wpbs_checker
// Port-level checks on the result channel of the band steering block.
// ----------------------------------------------------------------------------
module wpbs_checker (
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_ready,
  input wpbs_pkg::result_t result
);
  import wpbs_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(result))
    else $error("result dropped or changed while stalled");

  a_rst: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result valid right after reset");

  a_stop: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((result.direction == DIR_STOP) ==
      (result.left_count == '0 && result.center_count == '0 &&
       result.right_count == '0)))
    else $error("stop command does not match empty counts");

  a_left: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.direction == DIR_LEFT |->
      result.left_count >= result.center_count &&
      result.left_count >= result.right_count)
    else $error("left command without leading left count");

  a_right: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.direction == DIR_RIGHT |->
      result.right_count > result.left_count &&
      result.right_count > result.center_count)
    else $error("right command without strictly leading right count");

endmodule

bind white_pixel_band_steering wpbs_checker u_wpbs_checker (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_ready (result_ready),
  .result       (result)
);

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for white_pixel_band_steering. Directed table rows
// of pixels and register writes run first, then a long output stall, then
// randomized phases of small frames, geometry and white level changed
// between them (often mid-frame), with long runs at clamped geometry. Each
// result is matched field by field to its table row or an in-bench model.
// ----------------------------------------------------------------------------
module tb_top;
  import wpbs_pkg::*;

  localparam int          MAX_W            = 1024;
  localparam int          MAX_H            = 1024;
  localparam int          RANDOM_PIXELS    = 790;
  localparam int          CLAMP_RUN_W      = 350;
  localparam int          CLAMP_RUN_H      = 40;
  localparam int          SETTLE_CYCLES    = 16;
  localparam int          TAIL_CYCLES      = 20;
  localparam int          LONG_HOLD_CYCLES = 240;
  localparam int unsigned QUIET_LIMIT      = 3000;

  typedef enum logic {STIM_PIXEL, STIM_REGISTER} stim_kind_t;

  typedef struct {
    stim_kind_t             kind;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  value;
    pixel_t                 px;
    bit                     typed;
    result_t                res;
  } stim_row_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  pixel_valid;
  logic                  pixel_ready;
  pixel_t                pixel;
  logic                  result_valid;
  logic                  result_ready;
  result_t               result;

  white_pixel_band_steering #(
    .MAX_WIDTH  (MAX_W),
    .MAX_HEIGHT (MAX_H)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  // band tally model state
  logic [CFG_DATA_W-1:0] width_reg  = RST_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] height_reg = RST_FRAME_HEIGHT;
  logic [7:0]            level_reg  = RST_WHITE_LEVEL;
  int unsigned           col_at     = 0;
  int unsigned           row_at     = 0;
  logic [COUNT_W-1:0]    left_seen   = '0;
  logic [COUNT_W-1:0]    center_seen = '0;
  logic [COUNT_W-1:0]    right_seen  = '0;

  result_t     frame_results[$];
  result_t     oldest_frame;
  int unsigned failures       = 0;
  int unsigned frames_checked = 0;
  int unsigned pixels_sent    = 0;
  int unsigned reg_writes     = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned burst_left     = 0;
  bit          gaps_on        = 1'b1;
  bit          long_hold_req  = 1'b0;
  bit          long_hold_on   = 1'b0;

  function automatic int unsigned clamp_extent(input logic [CFG_DATA_W-1:0] v,
                                               input int unsigned limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return 32'(v);
  endfunction

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (&c) ? c : c + 1'b1;
  endfunction

  // Counts one pixel; returns 1 with the frame summary when it closes a frame.
  function automatic bit tally_pixel(input pixel_t px, output result_t summary);
    int unsigned w;
    int unsigned h;
    int unsigned c3;
    w = clamp_extent(width_reg, MAX_W);
    h = clamp_extent(height_reg, MAX_H);
    c3 = 3 * col_at;
    summary = '0;
    if (px.red == level_reg && px.green == level_reg && px.blue == level_reg) begin
      if (c3 <= w) left_seen = bump(left_seen);
      else if (c3 < 2 * w) center_seen = bump(center_seen);
      else if (c3 > 2 * w) right_seen = bump(right_seen);
    end
    if (col_at + 1 < w) begin
      col_at++;
      return 1'b0;
    end
    col_at = 0;
    if (row_at + 1 < h) begin
      row_at++;
      return 1'b0;
    end
    if (left_seen == 0 && center_seen == 0 && right_seen == 0)
      summary.direction = DIR_STOP;
    else if (left_seen >= center_seen && left_seen >= right_seen)
      summary.direction = DIR_LEFT;
    else if (center_seen >= right_seen)
      summary.direction = DIR_STRAIGHT;
    else
      summary.direction = DIR_RIGHT;
    summary.left_count   = left_seen;
    summary.center_count = center_seen;
    summary.right_count  = right_seen;
    row_at      = 0;
    left_seen   = '0;
    center_seen = '0;
    right_seen  = '0;
    return 1'b1;
  endfunction

  function automatic pixel_t make_pixel(input logic [7:0] lvl);
    pixel_t      px;
    int unsigned pick;
    int unsigned flip_at;
    pick    = $urandom_range(0, 9);
    flip_at = $urandom_range(0, 23);
    px      = {lvl, lvl, lvl};
    if (pick >= 7) px = 24'($urandom);
    else if (pick >= 4) px[flip_at] = ~px[flip_at];
    return px;
  endfunction

  function automatic stim_row_t pixel_row(input logic [7:0] r, g, b);
    stim_row_t row;
    row       = '{kind: STIM_PIXEL, default: '0};
    row.px    = {r, g, b};
    return row;
  endfunction

  function automatic stim_row_t frame_end_row(input logic [7:0] r, g, b,
                                              input result_t res);
    stim_row_t row;
    row       = pixel_row(r, g, b);
    row.typed = 1'b1;
    row.res   = res;
    return row;
  endfunction

  function automatic stim_row_t register_row(input logic [CFG_IDX_W-1:0] idx,
                                             input logic [CFG_DATA_W-1:0] value);
    stim_row_t row;
    row       = '{kind: STIM_REGISTER, default: '0};
    row.index = idx;
    row.value = value;
    return row;
  endfunction

  // Stop offering, let every pending frame come out and the pipeline drain.
  task automatic settle_block();
    pixel_valid <= 1'b0;
    burst_left = 0;
    while (frame_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    reg_writes++;
    case (idx)
      CFG_FRAME_WIDTH:  width_reg  = value;
      CFG_FRAME_HEIGHT: height_reg = value;
      CFG_WHITE_LEVEL:  level_reg  = value[7:0];
      default: ;
    endcase
  endtask

  task automatic offer_pixel(input pixel_t px, input bit typed, input result_t typed_res);
    int unsigned gap;
    result_t     summary;
    if (burst_left == 0) begin
      gap = gaps_on ? $urandom_range(0, 8) : 0;
      if (gap != 0) begin
        pixel_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    do @(posedge clk); while (!pixel_ready);
    burst_left--;
    pixels_sent++;
    if (tally_pixel(px, summary)) frame_results.push_back(typed ? typed_res : summary);
  endtask

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // result side: random stall pattern plus one long hold on request
  initial begin : receiver
    int unsigned seg_len;
    int unsigned style;
    result_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        long_hold_on  = 1'b1;
        result_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk);
        long_hold_on = 1'b0;
      end
      style   = $urandom_range(0, 3);
      seg_len = $urandom_range(4, 40);
      repeat (seg_len) begin
        case (style)
          0:       result_ready <= 1'b1;
          1:       result_ready <= 1'($urandom_range(0, 1));
          2:       result_ready <= ($urandom_range(0, 3) == 0);
          default: result_ready <= ($urandom_range(0, 7) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) begin
      if (frame_results.size() == 0) begin
        $error("result transfer with no frame pending: %p", result);
        failures++;
      end else begin
        oldest_frame = frame_results.pop_front();
        frames_checked++;
        if (result.direction !== oldest_frame.direction) begin
          $error("direction: expected %0d, got %0d", oldest_frame.direction,
                 result.direction);
          failures++;
        end
        if (result.left_count !== oldest_frame.left_count) begin
          $error("left_count: expected %0d, got %0d", oldest_frame.left_count,
                 result.left_count);
          failures++;
        end
        if (result.center_count !== oldest_frame.center_count) begin
          $error("center_count: expected %0d, got %0d", oldest_frame.center_count,
                 result.center_count);
          failures++;
        end
        if (result.right_count !== oldest_frame.right_count) begin
          $error("right_count: expected %0d, got %0d", oldest_frame.right_count,
                 result.right_count);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((pixel_valid && pixel_ready) || (result_valid && result_ready) || cfg_we)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", quiet_cycles);
      $display("white_pixel_band_steering: mismatch");
      $finish;
    end
  end

  initial begin
    stim_row_t             rows[$];
    stim_row_t             row;
    int unsigned           random_pixels;
    int unsigned           phase;
    int unsigned           count;
    int unsigned           directed_pixels;
    logic [CFG_DATA_W-1:0] new_w;
    logic [CFG_DATA_W-1:0] new_h;
    logic [7:0]            new_level;

    rst         = 1'b1;
    cfg_we      = 1'b0;
    cfg_index   = CFG_FRAME_WIDTH;
    cfg_data    = '0;
    pixel_valid = 1'b0;
    pixel       = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // white level still at its reset value for the first three frames
    rows.push_back(register_row(CFG_FRAME_WIDTH, 11'd3));
    rows.push_back(register_row(CFG_FRAME_HEIGHT, 11'd1));
    rows.push_back(pixel_row(8'd0, 8'd0, 8'd0));
    rows.push_back(pixel_row(8'd0, 8'd0, 8'd0));
    rows.push_back(frame_end_row(8'd0, 8'd0, 8'd0,
                                 result_t'{DIR_STOP, 21'd0, 21'd0, 21'd0}));
    // third column sits exactly on 3*col == 2*W: in no band
    rows.push_back(pixel_row(8'd255, 8'd255, 8'd255));
    rows.push_back(pixel_row(8'd255, 8'd255, 8'd255));
    rows.push_back(frame_end_row(8'd255, 8'd255, 8'd255,
                                 result_t'{DIR_LEFT, 21'd2, 21'd0, 21'd0}));
    rows.push_back(pixel_row(8'd255, 8'd255, 8'd254));
    rows.push_back(pixel_row(8'd255, 8'd254, 8'd255));
    rows.push_back(frame_end_row(8'd254, 8'd255, 8'd255,
                                 result_t'{DIR_STOP, 21'd0, 21'd0, 21'd0}));
    // center/right tie goes to center
    rows.push_back(register_row(CFG_FRAME_WIDTH, 11'd6));
    rows.push_back(pixel_row(8'd0, 8'd0, 8'd0));
    rows.push_back(pixel_row(8'd0, 8'd0, 8'd0));
    rows.push_back(pixel_row(8'd0, 8'd0, 8'd0));
    rows.push_back(pixel_row(8'd255, 8'd255, 8'd255));
    rows.push_back(pixel_row(8'd255, 8'd255, 8'd255));
    rows.push_back(frame_end_row(8'd255, 8'd255, 8'd255,
                                 result_t'{DIR_STRAIGHT, 21'd0, 21'd1, 21'd1}));
    // white level zero; left/right tie goes to left
    rows.push_back(register_row(CFG_WHITE_LEVEL, 11'd0));
    rows.push_back(pixel_row(8'd0, 8'd0, 8'd0));
    rows.push_back(pixel_row(8'd0, 8'd0, 8'd1));
    rows.push_back(pixel_row(8'd0, 8'd1, 8'd0));
    rows.push_back(pixel_row(8'd1, 8'd0, 8'd0));
    rows.push_back(pixel_row(8'd0, 8'd0, 8'd0));
    rows.push_back(frame_end_row(8'd0, 8'd0, 8'd0,
                                 result_t'{DIR_LEFT, 21'd1, 21'd0, 21'd1}));
    // zero geometry behaves as 1 x 1
    rows.push_back(register_row(CFG_FRAME_WIDTH, 11'd0));
    rows.push_back(register_row(CFG_FRAME_HEIGHT, 11'd0));
    rows.push_back(frame_end_row(8'd0, 8'd0, 8'd0,
                                 result_t'{DIR_LEFT, 21'd1, 21'd0, 21'd0}));
    rows.push_back(frame_end_row(8'd255, 8'd255, 8'd255,
                                 result_t'{DIR_STOP, 21'd0, 21'd0, 21'd0}));

    foreach (rows[i]) begin
      row = rows[i];
      if (row.kind == STIM_REGISTER) write_register(row.index, row.value);
      else offer_pixel(row.px, row.typed, row.res);
    end
    directed_pixels = pixels_sent;

    // long output stall with 1 x 1 frames: the block must back up its input
    settle_block();
    gaps_on = 1'b0;
    long_hold_req = 1'b1;
    while (!long_hold_on) @(posedge clk);
    repeat (40) offer_pixel(make_pixel(level_reg), 1'b0, '0);

    random_pixels = 0;
    phase = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      if (phase == 4 || phase == 9) begin
        // close the open frame, run long at a clamped dimension, then shrink
        // the geometry so the next pixel ends the frame
        count = pixels_sent;
        while (col_at != 0 || row_at != 0) offer_pixel(make_pixel(level_reg), 1'b0, '0);
        write_register(CFG_FRAME_WIDTH, (phase == 4) ? 11'd2047 : 11'd1);
        write_register(CFG_FRAME_HEIGHT, (phase == 4) ? 11'd0 : 11'd2047);
        gaps_on = 1'b1;
        repeat ((phase == 4) ? CLAMP_RUN_W : CLAMP_RUN_H)
          offer_pixel(make_pixel(level_reg), 1'b0, '0);
        write_register(CFG_FRAME_WIDTH, 11'd1);
        write_register(CFG_FRAME_HEIGHT, 11'd1);
        offer_pixel(make_pixel(level_reg), 1'b0, '0);
        random_pixels += pixels_sent - count;
      end
      case ($urandom_range(0, 7))
        0:       new_w = 11'd0;
        1:       new_w = 11'd1;
        2, 3:    new_w = 11'(3 * $urandom_range(1, 4));
        default: new_w = 11'($urandom_range(2, 12));
      endcase
      new_h = 11'($urandom_range(0, 3));
      case ($urandom_range(0, 3))
        0:       new_level = 8'd0;
        1:       new_level = 8'd255;
        default: new_level = 8'($urandom_range(0, 255));
      endcase
      // geometry changes land mid-frame since phase lengths ignore frame size
      if (phase == 0 || $urandom_range(0, 2) != 0) write_register(CFG_FRAME_WIDTH, new_w);
      if (phase == 0 || $urandom_range(0, 2) != 0) write_register(CFG_FRAME_HEIGHT, new_h);
      if (phase == 0 || $urandom_range(0, 2) != 0)
        write_register(CFG_WHITE_LEVEL, {3'($urandom_range(0, 7)), new_level});
      gaps_on = ($urandom_range(0, 3) != 0);
      count = $urandom_range(1, 48);
      repeat (count) offer_pixel(make_pixel(level_reg), 1'b0, '0);
      random_pixels += count;
      phase++;
    end

    settle_block();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d pixels (%0d directed) in %0d phases, %0d frame results, %0d reg writes",
             pixels_sent, directed_pixels, phase, frames_checked, reg_writes);
    $display("geometry 1x1 up to clamped width and height, incl. mid-frame changes");
    if (failures == 0)
      $display("white_pixel_band_steering: match");
    else
      $display("white_pixel_band_steering: mismatch");
    $finish;
  end

endmodule
